FILE: rtl/imu_fra_pkg.sv
// Shared types and constants for the IMU frame rotate and average block.
`timescale 1ns / 1ps
package imu_fra_pkg;

  // Default ring depth for the force moving average
  localparam int MAX_WINDOW_DEF = 64;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_GYRO_BIAS     = 3'd1,
    REG_ACCEL_BIAS    = 3'd2,
    REG_AVG_WINDOW    = 3'd3,
    REG_GRAVITY_X     = 3'd4,
    REG_GRAVITY_Y     = 3'd5,
    REG_GRAVITY_Z     = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [6:0]         AVG_WINDOW_RST = 7'd50;
  localparam logic signed [31:0] GRAVITY_Z_RST  = -32'sd642908;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QMUL,
    ST_MAT,
    ST_ROT,
    ST_EV_CHK,
    ST_EV_SUB,
    ST_PUSH,
    ST_DSET,
    ST_DIV,
    ST_DFIN,
    ST_OUT
  } state_t;

  // Saturate a widened value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Negate a Q2.14 value, most negative code maps to most positive
  function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == 16'sh8000) begin
      r = 16'sh7FFF;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/imu_fra_if.sv
// Valid/ready channel interfaces for IMU samples and results.
`timescale 1ns / 1ps
interface imu_fra_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_time;
  logic signed [15:0] orient_w;
  logic signed [15:0] orient_x;
  logic signed [15:0] orient_y;
  logic signed [15:0] orient_z;
  logic signed [31:0] rate_world_x;
  logic signed [31:0] rate_world_y;
  logic signed [31:0] rate_world_z;
  logic signed [31:0] accel_world_x;
  logic signed [31:0] accel_world_y;
  logic signed [31:0] accel_world_z;

  modport source (
    output valid, sample_time, orient_w, orient_x, orient_y, orient_z,
           rate_world_x, rate_world_y, rate_world_z,
           accel_world_x, accel_world_y, accel_world_z,
    input  ready
  );
  modport sink (
    input  valid, sample_time, orient_w, orient_x, orient_y, orient_z,
           rate_world_x, rate_world_y, rate_world_z,
           accel_world_x, accel_world_y, accel_world_z,
    output ready
  );
endinterface

interface imu_fra_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] orient_out_w;
  logic signed [15:0] orient_out_x;
  logic signed [15:0] orient_out_y;
  logic signed [15:0] orient_out_z;
  logic signed [31:0] rate_body_x;
  logic signed [31:0] rate_body_y;
  logic signed [31:0] rate_body_z;
  logic signed [31:0] force_body_x;
  logic signed [31:0] force_body_y;
  logic signed [31:0] force_body_z;

  modport source (
    output valid, orient_out_w, orient_out_x, orient_out_y, orient_out_z,
           rate_body_x, rate_body_y, rate_body_z,
           force_body_x, force_body_y, force_body_z,
    input  ready
  );
  modport sink (
    input  valid, orient_out_w, orient_out_x, orient_out_y, orient_out_z,
           rate_body_x, rate_body_y, rate_body_z,
           force_body_x, force_body_y, force_body_z,
    output ready
  );
endinterface

FILE: rtl/imu_frame_rotate_and_average.sv
// IMU frame rotation, bias and specific-force moving average (top level).
// Sequence: quaternion products, matrix build, rotation multiply-accumulates for both
//   vectors, a window check repeated with a subtract per evicted entry, push, a restoring divide
//   of SW = 33 + clog2(MAX_WINDOW) bits and the output load; bypass skips push and divide.
// Flow: one sample at a time; the next sample is accepted from the cycle after the output load,
//   which is held while a result waits; a dropped sample is accepted and discarded in idle.
// Reset: synchronous, clears control, sums, count, head and registers.
`timescale 1ns / 1ps
module imu_frame_rotate_and_average #(
  parameter int MAX_WINDOW = imu_fra_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [imu_fra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                        cfg_wdata,
  imu_fra_in_if.sink                         sample,
  imu_fra_out_if.source                      result
);

  localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int EW  = (CW > 7) ? CW : 7;
  localparam int SW  = $clog2(MAX_WINDOW) + 33;
  localparam int DCW = $clog2(SW + 1);

  // Configuration registers
  logic [31:0]        sample_period;
  logic signed [31:0] gyro_offset;
  logic signed [31:0] accel_offset;
  logic [6:0]         avg_window;
  logic signed [31:0] gravity_x;
  logic signed [31:0] gravity_y;
  logic signed [31:0] gravity_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= '0;
      gyro_offset   <= '0;
      accel_offset  <= '0;
      avg_window    <= imu_fra_pkg::AVG_WINDOW_RST;
      gravity_x     <= '0;
      gravity_y     <= '0;
      gravity_z     <= imu_fra_pkg::GRAVITY_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imu_fra_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg_wdata;
        imu_fra_pkg::REG_GYRO_BIAS:     gyro_offset   <= cfg_wdata;
        imu_fra_pkg::REG_ACCEL_BIAS:    accel_offset  <= cfg_wdata;
        imu_fra_pkg::REG_AVG_WINDOW:    avg_window    <= cfg_wdata[6:0];
        imu_fra_pkg::REG_GRAVITY_X:     gravity_x     <= cfg_wdata;
        imu_fra_pkg::REG_GRAVITY_Y:     gravity_y     <= cfg_wdata;
        imu_fra_pkg::REG_GRAVITY_Z:     gravity_z     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective window, clamped to the ring depth
  logic [EW-1:0] avg_ext;
  logic [CW-1:0] win;
  logic          avg_on;
  assign avg_ext = EW'(avg_window);
  assign win     = (avg_ext > EW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(avg_ext);
  assign avg_on  = (win > CW'(1));

  imu_fra_pkg::state_t state, state_next;

  // Control and datapath registers
  logic [31:0]        last_emit_time;
  logic signed [15:0] q [4];
  logic signed [31:0] rw [3];
  logic signed [32:0] fw [3];
  logic signed [31:0] qp [9];
  logic signed [21:0] m [9];
  logic [3:0]         step;
  logic [1:0]         row, col;
  logic               vsel;
  logic signed [57:0] acc;
  logic signed [31:0] rb [3];
  logic signed [31:0] fb [3];
  logic signed [31:0] fo [3];
  logic signed [SW-1:0] sum [3];
  logic [CW-1:0]      count;
  logic [AW-1:0]      head;
  logic [SW-1:0]      quo [3];
  logic [CW:0]        rem [3];
  logic [2:0]         neg;
  logic [DCW-1:0]     div_cnt;
  logic               out_valid;

  // History ring, one entry holds three forces
  logic [95:0]   hist_mem [MAX_WINDOW];
  logic [95:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // Input gate on the time since the last emitted sample
  logic        in_fire;
  logic        pass;
  logic [31:0] dt;
  assign sample.ready = (state == imu_fra_pkg::ST_IDLE);
  assign in_fire      = sample.valid && sample.ready;
  assign dt           = sample.sample_time - last_emit_time;
  assign pass         = (sample_period == '0) || (dt >= sample_period);

  // Shared multiplier operands
  logic signed [21:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [54:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == imu_fra_pkg::ST_ROT) begin
      mul_a = m[{row, 2'b00} - {2'b00, row} + {2'b00, col}];
      mul_b = vsel ? fw[col] : 33'(rw[col]);
    end else begin
      case (step)
        4'd0: begin mul_a = 22'(q[2]); mul_b = 33'(q[2]); end
        4'd1: begin mul_a = 22'(q[3]); mul_b = 33'(q[3]); end
        4'd2: begin mul_a = 22'(q[1]); mul_b = 33'(q[2]); end
        4'd3: begin mul_a = 22'(q[0]); mul_b = 33'(q[3]); end
        4'd4: begin mul_a = 22'(q[1]); mul_b = 33'(q[3]); end
        4'd5: begin mul_a = 22'(q[0]); mul_b = 33'(q[2]); end
        4'd6: begin mul_a = 22'(q[1]); mul_b = 33'(q[1]); end
        4'd7: begin mul_a = 22'(q[2]); mul_b = 33'(q[3]); end
        default: begin mul_a = 22'(q[0]); mul_b = 33'(q[1]); end
      endcase
    end
  end
  assign prod = mul_a * mul_b;

  // Matrix elements from the quaternion products, rounded to 2^-14
  logic signed [35:0] mraw [9];
  logic signed [35:0] one28;
  assign one28 = 36'sd268435456;
  always_comb begin
    // qp: 0 yy, 1 zz, 2 xy, 3 wz, 4 xz, 5 wy, 6 xx, 7 yz, 8 wx
    mraw[0] = one28 - 36'sd2 * (36'(qp[0]) + 36'(qp[1]));
    mraw[1] = 36'sd2 * (36'(qp[2]) + 36'(qp[3]));
    mraw[2] = 36'sd2 * (36'(qp[4]) - 36'(qp[5]));
    mraw[3] = 36'sd2 * (36'(qp[2]) - 36'(qp[3]));
    mraw[4] = one28 - 36'sd2 * (36'(qp[6]) + 36'(qp[1]));
    mraw[5] = 36'sd2 * (36'(qp[7]) + 36'(qp[8]));
    mraw[6] = 36'sd2 * (36'(qp[4]) + 36'(qp[5]));
    mraw[7] = 36'sd2 * (36'(qp[7]) - 36'(qp[8]));
    mraw[8] = one28 - 36'sd2 * (36'(qp[6]) + 36'(qp[0]));
  end

  // Rotation accumulate, round and bias
  logic signed [57:0] acc_sum;
  logic signed [57:0] acc_rnd;
  logic signed [47:0] biased;
  assign acc_sum = acc + 58'(prod);
  assign acc_rnd = (acc_sum + 58'sd8192) >>> 14;
  assign biased  = 48'($signed(acc_rnd[44:0])) + 48'(vsel ? accel_offset : gyro_offset);

  // Oldest ring entry
  logic [CW:0] old_tmp;
  logic [CW:0] old_wrap;
  logic        evict;
  assign old_tmp  = (CW+1)'(head) + (CW+1)'(MAX_WINDOW) - (CW+1)'(count);
  assign old_wrap = (old_tmp >= (CW+1)'(MAX_WINDOW)) ?
                    old_tmp - (CW+1)'(MAX_WINDOW) : old_tmp;
  assign evict    = (count >= win) && (count != '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      imu_fra_pkg::ST_IDLE:   if (in_fire && pass) state_next = imu_fra_pkg::ST_QMUL;
      imu_fra_pkg::ST_QMUL:   if (step == 4'd8) state_next = imu_fra_pkg::ST_MAT;
      imu_fra_pkg::ST_MAT:    state_next = imu_fra_pkg::ST_ROT;
      imu_fra_pkg::ST_ROT: begin
        if (vsel && row == 2'd2 && col == 2'd2) state_next = imu_fra_pkg::ST_EV_CHK;
      end
      imu_fra_pkg::ST_EV_CHK: begin
        if (!avg_on)    state_next = imu_fra_pkg::ST_OUT;
        else if (evict) state_next = imu_fra_pkg::ST_EV_SUB;
        else            state_next = imu_fra_pkg::ST_PUSH;
      end
      imu_fra_pkg::ST_EV_SUB: state_next = imu_fra_pkg::ST_EV_CHK;
      imu_fra_pkg::ST_PUSH:   state_next = imu_fra_pkg::ST_DSET;
      imu_fra_pkg::ST_DSET:   state_next = imu_fra_pkg::ST_DIV;
      imu_fra_pkg::ST_DIV:    if (div_cnt == DCW'(SW - 1)) state_next = imu_fra_pkg::ST_DFIN;
      imu_fra_pkg::ST_DFIN:   state_next = imu_fra_pkg::ST_OUT;
      imu_fra_pkg::ST_OUT:    if (!out_valid || result.ready) state_next = imu_fra_pkg::ST_IDLE;
      default:                state_next = imu_fra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= imu_fra_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Ring memory, registered read
  assign mem_we  = (state == imu_fra_pkg::ST_PUSH);
  assign rd_addr = AW'(old_wrap);
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[head] <= {fb[2], fb[1], fb[0]};
    rd_data <= hist_mem[rd_addr];
  end

  // Result valid: set when the output registers load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == imu_fra_pkg::ST_OUT && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.valid && result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_emit_time <= '0;
      count          <= '0;
      head           <= '0;
      step           <= '0;
      row            <= '0;
      col            <= '0;
      vsel           <= 1'b0;
      div_cnt        <= '0;
      for (int i = 0; i < 3; i++) sum[i] <= '0;
    end else begin
      unique case (state)
        imu_fra_pkg::ST_IDLE: begin
          step <= '0;
          if (in_fire && pass) last_emit_time <= sample.sample_time;
        end
        imu_fra_pkg::ST_QMUL: step <= step + 4'd1;
        imu_fra_pkg::ST_MAT: begin
          row  <= '0;
          col  <= '0;
          vsel <= 1'b0;
        end
        imu_fra_pkg::ST_ROT: begin
          if (col == 2'd2) begin
            col <= '0;
            if (row == 2'd2) begin
              row  <= '0;
              vsel <= 1'b1;
            end else begin
              row <= row + 2'd1;
            end
          end else begin
            col <= col + 2'd1;
          end
        end
        imu_fra_pkg::ST_EV_SUB: begin
          sum[0] <= sum[0] - SW'($signed(rd_data[31:0]));
          sum[1] <= sum[1] - SW'($signed(rd_data[63:32]));
          sum[2] <= sum[2] - SW'($signed(rd_data[95:64]));
          count  <= count - CW'(1);
        end
        imu_fra_pkg::ST_PUSH: begin
          for (int i = 0; i < 3; i++) sum[i] <= sum[i] + SW'(fb[i]);
          head  <= (head == AW'(MAX_WINDOW - 1)) ? '0 : head + AW'(1);
          count <= count + CW'(1);
        end
        imu_fra_pkg::ST_DSET: div_cnt <= '0;
        imu_fra_pkg::ST_DIV:  div_cnt <= div_cnt + DCW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers
  logic [CW:0]   dshift [3];
  logic [CW+1:0] ddiff [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dshift[i] = {rem[i][CW-1:0], quo[i][SW-1]};
      ddiff[i]  = (CW+2)'(dshift[i]) - (CW+2)'(count);
    end
  end

  logic signed [15:0] o_w, o_x, o_y, o_z;
  logic signed [31:0] o_rb [3];
  logic signed [31:0] o_fo [3];

  always_ff @(posedge clk) begin
    unique case (state)
      imu_fra_pkg::ST_IDLE: begin
        q[0]  <= sample.orient_w;
        q[1]  <= sample.orient_x;
        q[2]  <= sample.orient_y;
        q[3]  <= sample.orient_z;
        rw[0] <= sample.rate_world_x;
        rw[1] <= sample.rate_world_y;
        rw[2] <= sample.rate_world_z;
        fw[0] <= 33'(sample.accel_world_x) - 33'(gravity_x);
        fw[1] <= 33'(sample.accel_world_y) - 33'(gravity_y);
        fw[2] <= 33'(sample.accel_world_z) - 33'(gravity_z);
        acc   <= '0;
      end
      imu_fra_pkg::ST_QMUL: qp[step] <= prod[31:0];
      imu_fra_pkg::ST_MAT: begin
        for (int i = 0; i < 9; i++) m[i] <= 22'((mraw[i] + 36'sd8192) >>> 14);
      end
      imu_fra_pkg::ST_ROT: begin
        if (col == 2'd2) begin
          acc <= '0;
          if (vsel) fb[row] <= imu_fra_pkg::sat32(biased);
          else      rb[row] <= imu_fra_pkg::sat32(biased);
        end else begin
          acc <= acc_sum;
        end
      end
      imu_fra_pkg::ST_EV_CHK: begin
        if (!avg_on) for (int i = 0; i < 3; i++) fo[i] <= fb[i];
      end
      imu_fra_pkg::ST_DSET: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= sum[i][SW-1];
          quo[i] <= sum[i][SW-1] ? -sum[i] : sum[i];
          rem[i] <= '0;
        end
      end
      imu_fra_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle on each axis
        for (int i = 0; i < 3; i++) begin
          if (!ddiff[i][CW+1]) begin
            rem[i] <= ddiff[i][CW:0];
            quo[i] <= {quo[i][SW-2:0], 1'b1};
          end else begin
            rem[i] <= dshift[i];
            quo[i] <= {quo[i][SW-2:0], 1'b0};
          end
        end
      end
      imu_fra_pkg::ST_DFIN: begin
        for (int i = 0; i < 3; i++) begin
          if (neg[i]) begin
            fo[i] <= (quo[i] > SW'(32'h8000_0000)) ? 32'sh8000_0000 : -quo[i][31:0];
          end else begin
            fo[i] <= (quo[i] > SW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo[i][31:0];
          end
        end
      end
      imu_fra_pkg::ST_OUT: begin
        if (!out_valid || result.ready) begin
          o_w <= q[0];
          o_x <= imu_fra_pkg::neg16(q[1]);
          o_y <= imu_fra_pkg::neg16(q[2]);
          o_z <= imu_fra_pkg::neg16(q[3]);
          for (int i = 0; i < 3; i++) begin
            o_rb[i] <= rb[i];
            o_fo[i] <= fo[i];
          end
        end
      end
      default: ;
    endcase
  end

  // Result channel
  assign result.valid        = out_valid;
  assign result.orient_out_w = o_w;
  assign result.orient_out_x = o_x;
  assign result.orient_out_y = o_y;
  assign result.orient_out_z = o_z;
  assign result.rate_body_x  = o_rb[0];
  assign result.rate_body_y  = o_rb[1];
  assign result.rate_body_z  = o_rb[2];
  assign result.force_body_x = o_fo[0];
  assign result.force_body_y = o_fo[1];
  assign result.force_body_z = o_fo[2];

endmodule

FILE: tb/sv/imu_fra_checker.sv
// Checker for the IMU frame rotate and average block: predicts each sample and compares results.
`timescale 1ns / 1ps
module imu_fra_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [imu_fra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                       cfg_wdata,
  imu_fra_in_if                             smp,
  imu_fra_out_if                            res,
  output int                                fail_count,
  output int                                pending,
  output int                                emitted_count,
  output int                                dropped_count
);

  localparam int RING = imu_fra_pkg::MAX_WINDOW_DEF;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] rate [3];
    logic signed [31:0] spec_f [3];
  } body_sample_t;

  // Mirrored configuration
  logic [31:0]        period_r;
  logic signed [31:0] gyro_b, accel_b;
  logic [6:0]         window_r;
  logic signed [31:0] grav [3];

  // Mirrored gate and averaging state
  logic [31:0] last_emit;
  longint      ring_mem [RING][3];
  longint      force_sum [3];
  int          fill, head;

  body_sample_t expected_q [$];

  function automatic longint round_q14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [15:0] conj_part(logic signed [15:0] v);
    if (v == 16'sh8000) return 16'sh7FFF;
    return -v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Work out the result for one accepted sample, if it passes the time gate
  task automatic forecast_sample();
    body_sample_t e;
    longint w, x, y, z, one;
    longint m [3][3];
    longint rv [3], fv [3];
    longint acc_r, acc_f, old_idx;
    int eff;
    w = smp.orient_w;
    x = smp.orient_x;
    y = smp.orient_y;
    z = smp.orient_z;
    one = 64'sd1 <<< 28;
    if (period_r != 0 && (smp.sample_time - last_emit) < period_r) begin
      dropped_count++;
      return;
    end
    last_emit = smp.sample_time;
    m[0][0] = round_q14(one - 2 * (y * y + z * z));
    m[0][1] = round_q14(2 * (x * y + w * z));
    m[0][2] = round_q14(2 * (x * z - w * y));
    m[1][0] = round_q14(2 * (x * y - w * z));
    m[1][1] = round_q14(one - 2 * (x * x + z * z));
    m[1][2] = round_q14(2 * (y * z + w * x));
    m[2][0] = round_q14(2 * (x * z + w * y));
    m[2][1] = round_q14(2 * (y * z - w * x));
    m[2][2] = round_q14(one - 2 * (x * x + y * y));
    rv[0] = smp.rate_world_x;
    rv[1] = smp.rate_world_y;
    rv[2] = smp.rate_world_z;
    fv[0] = longint'(smp.accel_world_x) - longint'(grav[0]);
    fv[1] = longint'(smp.accel_world_y) - longint'(grav[1]);
    fv[2] = longint'(smp.accel_world_z) - longint'(grav[2]);
    for (int r = 0; r < 3; r++) begin
      acc_r = round_q14(m[r][0] * rv[0] + m[r][1] * rv[1] + m[r][2] * rv[2]);
      acc_f = round_q14(m[r][0] * fv[0] + m[r][1] * fv[1] + m[r][2] * fv[2]);
      e.rate[r]   = 32'(clamp_s32(acc_r + longint'(gyro_b)));
      e.spec_f[r] = 32'(clamp_s32(acc_f + longint'(accel_b)));
    end
    // Moving average over the ring, evicting down to the window first
    eff = (window_r > RING) ? RING : int'(window_r);
    if (eff > 1) begin
      while (fill >= eff && fill > 0) begin
        old_idx = (head + RING - fill) % RING;
        for (int a = 0; a < 3; a++) force_sum[a] -= ring_mem[old_idx][a];
        fill--;
      end
      for (int a = 0; a < 3; a++) begin
        ring_mem[head][a] = e.spec_f[a];
        force_sum[a] += e.spec_f[a];
      end
      head = (head + 1) % RING;
      fill++;
      for (int a = 0; a < 3; a++) e.spec_f[a] = 32'(clamp_s32(force_sum[a] / fill));
    end
    e.qw = smp.orient_w;
    e.qx = conj_part(smp.orient_x);
    e.qy = conj_part(smp.orient_y);
    e.qz = conj_part(smp.orient_z);
    expected_q = {expected_q, e};
    emitted_count++;
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic compare_result();
    body_sample_t e;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result transaction", 1, 0);
      return;
    end
    e = expected_q[0];
    expected_q.delete(0);
    if (res.orient_out_w !== e.qw) report_mismatch("orient_out_w", res.orient_out_w, e.qw);
    if (res.orient_out_x !== e.qx) report_mismatch("orient_out_x", res.orient_out_x, e.qx);
    if (res.orient_out_y !== e.qy) report_mismatch("orient_out_y", res.orient_out_y, e.qy);
    if (res.orient_out_z !== e.qz) report_mismatch("orient_out_z", res.orient_out_z, e.qz);
    if (res.rate_body_x !== e.rate[0]) report_mismatch("rate_body_x", res.rate_body_x, e.rate[0]);
    if (res.rate_body_y !== e.rate[1]) report_mismatch("rate_body_y", res.rate_body_y, e.rate[1]);
    if (res.rate_body_z !== e.rate[2]) report_mismatch("rate_body_z", res.rate_body_z, e.rate[2]);
    if (res.force_body_x !== e.spec_f[0])
      report_mismatch("force_body_x", res.force_body_x, e.spec_f[0]);
    if (res.force_body_y !== e.spec_f[1])
      report_mismatch("force_body_y", res.force_body_y, e.spec_f[1]);
    if (res.force_body_z !== e.spec_f[2])
      report_mismatch("force_body_z", res.force_body_z, e.spec_f[2]);
  endtask

  // Watch reset, register writes and both channels
  always @(posedge clk) begin
    if (rst) begin
      fail_count    = 0;
      emitted_count = 0;
      dropped_count = 0;
      period_r  = '0;
      gyro_b    = '0;
      accel_b   = '0;
      window_r  = imu_fra_pkg::AVG_WINDOW_RST;
      grav[0]   = '0;
      grav[1]   = '0;
      grav[2]   = imu_fra_pkg::GRAVITY_Z_RST;
      last_emit = '0;
      force_sum = '{0, 0, 0};
      fill      = 0;
      head      = 0;
      expected_q.delete();
    end else begin
      if (res.valid && res.ready) compare_result();
      if (smp.valid && smp.ready) forecast_sample();
      if (cfg_we) begin
        unique case (imu_fra_pkg::cfg_reg_t'(cfg_index))
          imu_fra_pkg::REG_SAMPLE_PERIOD: period_r = cfg_wdata;
          imu_fra_pkg::REG_GYRO_BIAS:     gyro_b   = cfg_wdata;
          imu_fra_pkg::REG_ACCEL_BIAS:    accel_b  = cfg_wdata;
          imu_fra_pkg::REG_AVG_WINDOW:    window_r = cfg_wdata[6:0];
          imu_fra_pkg::REG_GRAVITY_X:     grav[0]  = cfg_wdata;
          imu_fra_pkg::REG_GRAVITY_Y:     grav[1]  = cfg_wdata;
          imu_fra_pkg::REG_GRAVITY_Z:     grav[2]  = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_LIMIT   = 8000;
  localparam int HOLD_CYCLES  = 1500;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [imu_fra_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                       cfg_wdata;

  imu_fra_in_if  in_ch ();
  imu_fra_out_if out_ch ();

  int fail_count, pending, emitted_count, dropped_count;
  int tx_idle, rx_idle, stall_token, n_sent, idle_run;
  logic [31:0] tick, cur_period;

  imu_frame_rotate_and_average uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample    (in_ch),
    .result    (out_ch)
  );

  imu_fra_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .smp           (in_ch),
    .res           (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .emitted_count (emitted_count),
    .dropped_count (dropped_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever the token moves
  initial begin
    int seen, hold;
    seen = 0;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_token != seen) begin
        seen = stall_token;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  initial begin
    idle_run = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input imu_fra_pkg::cfg_reg_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every expected result, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic offer(input logic [31:0] t, input logic [15:0] qw, qx, qy, qz,
                       input logic [31:0] r0, r1, r2, a0, a1, a2);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample_time   <= t;
    in_ch.orient_w      <= qw;
    in_ch.orient_x      <= qx;
    in_ch.orient_y      <= qy;
    in_ch.orient_z      <= qz;
    in_ch.rate_world_x  <= r0;
    in_ch.rate_world_y  <= r1;
    in_ch.rate_world_z  <= r2;
    in_ch.accel_world_x <= a0;
    in_ch.accel_world_y <= a1;
    in_ch.accel_world_z <= a2;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  function automatic logic [15:0] rand_quat_part();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 16'($urandom_range(32768) - 16384);
    if (sel < 9) return 16'($urandom);
    return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
  endfunction

  function automatic logic [31:0] rand_vec_part();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 32'($urandom_range(32'h0080_0000) - 32'h0040_0000);
    if (sel < 9) return $urandom;
    return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Random sample, with time steps sized around the current period
  task automatic rand_sample();
    if (cur_period == 0) tick = tick + $urandom_range(50);
    else tick = tick + $urandom_range(2 * cur_period + 2);
    offer(tick, rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
          rand_vec_part(), rand_vec_part(), rand_vec_part(),
          rand_vec_part(), rand_vec_part(), rand_vec_part());
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= imu_fra_pkg::REG_SAMPLE_PERIOD;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample_time   <= '0;
    in_ch.orient_w      <= '0;
    in_ch.orient_x      <= '0;
    in_ch.orient_y      <= '0;
    in_ch.orient_z      <= '0;
    in_ch.rate_world_x  <= '0;
    in_ch.rate_world_y  <= '0;
    in_ch.rate_world_z  <= '0;
    in_ch.accel_world_x <= '0;
    in_ch.accel_world_y <= '0;
    in_ch.accel_world_z <= '0;
    tx_idle     = 6;
    rx_idle     = 65;
    stall_token = 0;
    n_sent      = 0;
    tick        = '0;
    cur_period  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples at reset configuration (window 50, default gravity)
    offer(0, 16'sd16384, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    offer(5, 16'sd16384, 0, 0, 0, 32'sd65536, -32'sd65536, 32'sd131072,
          0, 0, -32'sd642908);
    offer(6, 16'sd11585, 16'sd11585, 0, 0, 32'sd65536, 32'sd65536, 0,
          32'sd65536, 0, 32'sd65536);
    offer(7, 16'sd11585, 0, 16'sd11585, 0, 32'sd65536, 32'sd65536, 0,
          32'sd65536, 0, 32'sd65536);
    offer(8, 16'sd11585, 0, 0, 16'sd11585, 32'sd65536, 32'sd65536, 0,
          32'sd65536, 0, 32'sd65536);
    offer(9, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer(10, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer(11, 16'sd16384, 16'h8000, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000,
          0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    offer(32'hFFFF_FFFF, 0, 16'sd16384, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    offer(12, -16'sd16384, 0, 0, 0, 32'sd100, 32'sd200, 32'sd300, 32'sd7, 32'sd8, 32'sd9);
    for (int i = 0; i < 8; i++) rand_sample();
    drain();

    // Every register written: period gate, biases, full window, gravity
    cur_period = 20;
    write_reg(imu_fra_pkg::REG_SAMPLE_PERIOD, cur_period);
    write_reg(imu_fra_pkg::REG_GYRO_BIAS, 32'sd3277);
    write_reg(imu_fra_pkg::REG_ACCEL_BIAS, -32'sd6554);
    write_reg(imu_fra_pkg::REG_AVG_WINDOW, 32'd64);
    write_reg(imu_fra_pkg::REG_GRAVITY_X, $urandom_range(32'h0010_0000) - 32'h0008_0000);
    write_reg(imu_fra_pkg::REG_GRAVITY_Y, $urandom_range(32'h0010_0000) - 32'h0008_0000);
    write_reg(imu_fra_pkg::REG_GRAVITY_Z, -32'sd642908);
    end_writes();
    for (int i = 0; i < 140; i++) rand_sample();
    drain();

    // Bypass with saturating biases; sender mostly idle, receiver mostly ready
    tx_idle = 65;
    rx_idle = 6;
    cur_period = 0;
    write_reg(imu_fra_pkg::REG_SAMPLE_PERIOD, 32'd0);
    write_reg(imu_fra_pkg::REG_AVG_WINDOW, 32'd1);
    write_reg(imu_fra_pkg::REG_GYRO_BIAS, 32'h7FFF_FFFF);
    write_reg(imu_fra_pkg::REG_ACCEL_BIAS, 32'h8000_0000);
    end_writes();
    for (int i = 0; i < 60; i++) rand_sample();
    // Sender pause until every outstanding result has come back
    drain();
    for (int i = 0; i < 60; i++) rand_sample();
    drain();

    // Oversized window, extreme gravity, long receiver hold-off
    tx_idle = 0;
    rx_idle = 0;
    write_reg(imu_fra_pkg::REG_AVG_WINDOW, 32'd127);
    write_reg(imu_fra_pkg::REG_GYRO_BIAS, 32'h8000_0000);
    write_reg(imu_fra_pkg::REG_ACCEL_BIAS, 32'h7FFF_FFFF);
    write_reg(imu_fra_pkg::REG_GRAVITY_X, 32'h8000_0000);
    write_reg(imu_fra_pkg::REG_GRAVITY_Y, 32'h7FFF_FFFF);
    write_reg(imu_fra_pkg::REG_GRAVITY_Z, 32'h8000_0000);
    end_writes();
    for (int i = 0; i < 20; i++) rand_sample();
    stall_token++;
    for (int i = 0; i < 130; i++) rand_sample();
    drain();

    // Shrink to window 2 with maximum period: most samples gated off
    cur_period = 32'hFFFF_FFFF;
    write_reg(imu_fra_pkg::REG_AVG_WINDOW, 32'd2);
    write_reg(imu_fra_pkg::REG_SAMPLE_PERIOD, cur_period);
    write_reg(imu_fra_pkg::REG_GRAVITY_X, 32'd0);
    write_reg(imu_fra_pkg::REG_GRAVITY_Y, 32'd0);
    write_reg(imu_fra_pkg::REG_GRAVITY_Z, -32'sd642908);
    end_writes();
    for (int i = 0; i < 10; i++) begin
      offer(tick + $urandom_range(1000), rand_quat_part(), rand_quat_part(),
            rand_quat_part(), rand_quat_part(), rand_vec_part(), rand_vec_part(),
            rand_vec_part(), rand_vec_part(), rand_vec_part(), rand_vec_part());
    end
    tick = tick - 1;
    offer(tick, 16'sd16384, 0, 0, 0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6);
    drain();

    // Period of one, then averaging off with zero window
    cur_period = 1;
    write_reg(imu_fra_pkg::REG_SAMPLE_PERIOD, cur_period);
    end_writes();
    for (int i = 0; i < 60; i++) rand_sample();
    drain();
    write_reg(imu_fra_pkg::REG_AVG_WINDOW, 32'd0);
    end_writes();
    for (int i = 0; i < 50; i++) rand_sample();
    drain();

    $display("Sent %0d samples: %0d produced results, %0d gated by the sample period.",
             n_sent, emitted_count, dropped_count);
    $display("Windows 50/64/1/127/2/0, saturating biases and gravity, stalls on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
